// File: rtl/time_ordered_event_queue_defines.svh
// Assertion macros for the time ordered event queue.
`ifndef TIME_ORDERED_EVENT_QUEUE_DEFINES_SVH
`define TIME_ORDERED_EVENT_QUEUE_DEFINES_SVH

// Condition that must hold at every clock edge out of reset.
`define TOEQ_ASSERT(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Same-cycle implication.
`define TOEQ_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

// File: rtl/toeq_pkg.sv
// Shared constants, types and ring pointer helpers for the event queue.
`default_nettype none

package toeq_pkg;

	localparam int RING_DEPTH = 256;
	localparam int PTR_W      = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
	localparam int FILL_W     = $clog2(RING_DEPTH + 1);

	typedef struct packed {
		logic [31:0]        a;
		logic [31:0]        b;
		logic [31:0]        c;
		logic [31:0]        d;
		logic signed [31:0] stamp;
	} event_t;

	typedef struct packed {
		logic             we;
		logic [PTR_W-1:0] waddr;
		event_t           wdata;
		logic [PTR_W-1:0] raddr;
	} ring_req_t;

	function automatic logic [PTR_W-1:0] ring_prev(input logic [PTR_W-1:0] p);
		return (p == '0) ? PTR_W'(RING_DEPTH - 1) : p - 1'b1;
	endfunction

	function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(RING_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

endpackage

`default_nettype wire

// File: rtl/toeq_ring.sv
// Event storage: one write port, one registered read port.
`default_nettype none

module toeq_ring
	import toeq_pkg::*;
(
	input  wire       clk,
	input  ring_req_t req,
	output event_t    rdata
);

	event_t mem [RING_DEPTH];

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
	end

	// read-before-write on a shared address
	always_ff @(posedge clk) begin
		rdata <= mem[req.raddr];
	end

endmodule

`default_nettype wire

// File: rtl/time_ordered_event_queue.sv
// Top level of the time ordered event queue: sequencer, pointers and result port.
`default_nettype none
`include "time_ordered_event_queue_defines.svh"

// Timestamp-sorted ring of RING_DEPTH events. Pulse start while busy is low to
// transfer one command (enqueue or dequeue); busy stays high until the command
// finishes. Each command produces exactly one result, shown on the result
// ports for a single cycle with done high; the receiver cannot stall it, so
// capture it on that cycle. An enqueue into an empty ring or a dequeue goes
// from the accepting edge straight to its reporting state, S_PUT or S_DEQ; an
// enqueue into a non-empty ring first walks back in S_CMP over the k (0 to
// RING_DEPTH-1) held events with a larger stamp: each of them is moved one
// slot up through the single memory port, one per cycle, by the one stamp
// comparator, and one more compare finds where the walk stops. When every held
// event is larger the walk ends at the tail without that last compare.
// An enqueue to a full ring or a dequeue from an empty one is
// answered with ok low on the cycle after the transfer and busy never rises.
// Equal stamps keep arrival order. fill is the event count after the command.
// No clearing pass runs after reset: only slots that hold events are read.

module time_ordered_event_queue
	import toeq_pkg::*;
(
	input  wire                clk,
	input  wire                arst_n,
	input  wire                start,
	output logic               busy,
	input  wire                command,
	input  wire  [31:0]        word_a,
	input  wire  [31:0]        word_b,
	input  wire  [31:0]        word_c,
	input  wire  [31:0]        word_d,
	input  wire  signed [31:0] stamp,
	output logic               done,
	output logic               ok,
	output logic [31:0]        out_a,
	output logic [31:0]        out_b,
	output logic [31:0]        out_c,
	output logic [31:0]        out_d,
	output logic signed [31:0] out_stamp,
	output logic [FILL_W-1:0]  fill
);

	localparam logic CMD_ENQ = 1'b0;

	// sequencer states
	localparam logic [1:0] S_IDLE = 2'd0; // waiting for a command
	localparam logic [1:0] S_CMP  = 2'd1; // walk back: compare, shift, read next
	localparam logic [1:0] S_PUT  = 2'd2; // write the new event, report
	localparam logic [1:0] S_DEQ  = 2'd3; // tail data arrives, report

	logic [1:0]        state_q;
	logic [PTR_W-1:0]  head_q, tail_q;
	logic [FILL_W-1:0] held_q;
	logic [PTR_W-1:0]  pos_q;   // slot that is free during the walk
	logic [PTR_W-1:0]  prv_q;   // slot whose data is on rdata in S_CMP
	event_t            key_q;   // event being enqueued

	logic done_q, ok_q;
	event_t            res_q;
	logic [FILL_W-1:0] fill_q;

	ring_req_t req;
	event_t    rdata;
	logic      accept, full, empty, later;
	event_t    in_evt;

	toeq_ring u_ring (
		.clk   (clk),
		.req   (req),
		.rdata (rdata)
	);

	assign accept = start && (state_q == S_IDLE);
	assign full   = (held_q == FILL_W'(RING_DEPTH));
	assign empty  = (held_q == '0);

	assign in_evt.a     = word_a;
	assign in_evt.b     = word_b;
	assign in_evt.c     = word_c;
	assign in_evt.d     = word_d;
	assign in_evt.stamp = stamp;

	// the shared comparator: new stamp strictly below the held one
	assign later = (key_q.stamp < rdata.stamp);

	// memory port steering
	always_comb begin
		req.we    = 1'b0;
		req.waddr = pos_q;
		req.wdata = key_q;
		req.raddr = ring_prev(prv_q);
		case (state_q)
			S_IDLE: begin
				req.raddr = (command == CMD_ENQ) ? ring_prev(head_q) : tail_q;
			end
			S_CMP: begin
				if (later) begin
					req.we    = 1'b1;
					req.wdata = rdata;
				end
			end
			S_PUT: begin
				req.we = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			head_q  <= '0;
			tail_q  <= '0;
			held_q  <= '0;
			done_q  <= 1'b0;
			ok_q    <= 1'b0;
			fill_q  <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if ((command == CMD_ENQ && full) || (command != CMD_ENQ && empty)) begin
							// rejected: answer at once, nothing changes
							done_q <= 1'b1;
							ok_q   <= 1'b0;
							fill_q <= held_q;
						end else if (command != CMD_ENQ) begin
							state_q <= S_DEQ;
						end else if (empty) begin
							state_q <= S_PUT;
						end else begin
							state_q <= S_CMP;
						end
					end
				end
				S_CMP: begin
					if (!later || prv_q == tail_q) begin
						state_q <= S_PUT;
					end
				end
				S_PUT: begin
					head_q  <= ring_next(head_q);
					held_q  <= held_q + 1'b1;
					done_q  <= 1'b1;
					ok_q    <= 1'b1;
					fill_q  <= held_q + 1'b1;
					state_q <= S_IDLE;
				end
				S_DEQ: begin
					tail_q  <= ring_next(tail_q);
					held_q  <= held_q - 1'b1;
					done_q  <= 1'b1;
					ok_q    <= 1'b1;
					fill_q  <= held_q - 1'b1;
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// walk pointers, key and result payload
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					key_q <= in_evt;
					pos_q <= head_q;
					prv_q <= ring_prev(head_q);
					res_q <= '0;
				end
			end
			S_CMP: begin
				if (later) begin
					pos_q <= prv_q;
					prv_q <= ring_prev(prv_q);
				end
			end
			S_DEQ: begin
				res_q <= rdata;
			end
			default: begin
			end
		endcase
	end

	assign busy      = (state_q != S_IDLE);
	assign done      = done_q;
	assign ok        = ok_q;
	assign out_a     = res_q.a;
	assign out_b     = res_q.b;
	assign out_c     = res_q.c;
	assign out_d     = res_q.d;
	assign out_stamp = res_q.stamp;
	assign fill      = fill_q;

	`TOEQ_ASSERT(a_held_range, held_q <= FILL_W'(RING_DEPTH), "event count beyond ring depth")
	`TOEQ_ASSERT_IMP(a_empty_ptrs, held_q == '0, head_q == tail_q, "empty ring with split pointers")
	`TOEQ_ASSERT_IMP(a_walk_adj, state_q == S_CMP, pos_q == ring_next(prv_q), "walk pointers not adjacent")
	`TOEQ_ASSERT_IMP(a_done_idle, done_q, state_q == S_IDLE, "result shown while busy")

endmodule

`default_nettype wire
